// ===== design/tkc_pkg.sv =====
// shared types, codes and widths for the transmit keying controller
`default_nettype none

package tkc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int COUNT_W     = 16;
    localparam int TAIL_W      = 12;
    localparam int BEEP_W      = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_FULL_DUPLEX     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_PERIODS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_KEYS_OTHER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP1_PERIODS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP2_PERIODS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_PERIODS    = 3'd5;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_TAIL  = 3'd2,
        MODE_BEEP1 = 3'd3,
        MODE_BEEP2 = 3'd4,
        MODE_LINK  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        PTT_OFF   = 2'd0,
        PTT_OTHER = 2'd1,
        PTT_AUDIO = 2'd2
    } ptt_t;

    typedef enum logic [2:0] {
        SRC_SILENCE = 3'd0,
        SRC_VOICE   = 3'd1,
        SRC_BEEP1   = 3'd2,
        SRC_BEEP2   = 3'd3,
        SRC_LINK    = 3'd4
    } src_t;

    typedef struct packed {
        logic               full_duplex;
        logic [TAIL_W-1:0]  tail_periods;
        logic               tail_keys_other;
        logic [BEEP_W-1:0]  beep1_periods;
        logic [BEEP_W-1:0]  beep2_periods;
        logic [BEEP_W-1:0]  link_beep_periods;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] period_count;
        logic               had_voice;
        ptt_t               ptt_level;
    } state_t;

    typedef struct packed {
        logic voice_queued;
        logic beacon_due;
        logic channel_busy;
        logic aux_beep_enable;
        logic aux_second_beep;
        logic link_associated;
    } item_t;

    typedef struct packed {
        ptt_t               ptt_drive;
        src_t               audio_source;
        logic [COUNT_W-1:0] beep_period;
        logic               voice_consumed;
        logic               subtone_allowed;
        logic               transmitting;
    } result_t;

endpackage

`default_nettype wire

// ===== design/transmit_keying_controller.sv =====
// transmit keying controller top level: input register, tick logic, result register
//
//  channel | signals                                       | dir
//  --------+-----------------------------------------------+-----
//  in      | in_valid in_ready + six tick flags            | in
//  out     | out_valid out_ready + six result fields       | out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | in
//
// one transaction per cycle sustained while out_ready is high; a tick is held
// in the input register and leaves through the result register
// the mode state updates when a tick moves from the input to the result register
// with the result stalled, one more tick is still taken into the input register
// reset clears the mode state, configuration and both valid flags; cfg is always ready
`default_nettype none

module transmit_keying_controller
    import tkc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   voice_queued,
    input  wire logic                   beacon_due,
    input  wire logic                   channel_busy,
    input  wire logic                   aux_beep_enable,
    input  wire logic                   aux_second_beep,
    input  wire logic                   link_associated,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  ptt_drive,
    output logic [2:0]                  audio_source,
    output logic [COUNT_W-1:0]          beep_period,
    output logic                        voice_consumed,
    output logic                        subtone_allowed,
    output logic                        transmitting,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    tkc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tkc_step u_step (
        .cfg  (cfg),
        .st   (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{mode: MODE_OFF, period_count: '0, had_voice: 1'b0,
                                ptt_level: PTT_OFF};
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.voice_queued    <= voice_queued;
            item_reg.beacon_due      <= beacon_due;
            item_reg.channel_busy    <= channel_busy;
            item_reg.aux_beep_enable <= aux_beep_enable;
            item_reg.aux_second_beep <= aux_second_beep;
            item_reg.link_associated <= link_associated;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign ptt_drive       = res_reg.ptt_drive;
    assign audio_source    = res_reg.audio_source;
    assign beep_period     = res_reg.beep_period;
    assign voice_consumed  = res_reg.voice_consumed;
    assign subtone_allowed = res_reg.subtone_allowed;
    assign transmitting    = res_reg.transmitting;

endmodule

`default_nettype wire

// ===== design/tkc_cfg_regs.sv =====
// configuration register file
`default_nettype none

module tkc_cfg_regs
    import tkc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FULL_DUPLEX:     cfg_next.full_duplex = cfg_data[0];
                REG_TAIL_PERIODS:    cfg_next.tail_periods = cfg_data[TAIL_W-1:0];
                REG_TAIL_KEYS_OTHER: cfg_next.tail_keys_other = cfg_data[0];
                REG_BEEP1_PERIODS:   cfg_next.beep1_periods = cfg_data[BEEP_W-1:0];
                REG_BEEP2_PERIODS:   cfg_next.beep2_periods = cfg_data[BEEP_W-1:0];
                REG_LINK_PERIODS:    cfg_next.link_beep_periods = cfg_data[BEEP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tkc_step.sv =====
// next-state and result logic for one tick
`default_nettype none

module tkc_step
    import tkc_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire state_t st,
    input  wire item_t  item,
    output state_t      nxt,
    output result_t     res
);

    logic               bcn;
    logic               req;
    mode_t              m;
    logic [COUNT_W-1:0] c;
    logic               hv;
    ptt_t               np;
    logic               in_tail;
    logic               run_beep;
    logic               run_tail;
    logic               done;
    logic               consumed;
    src_t               src;
    logic [COUNT_W-1:0] bp;

    always_comb
    begin
        bcn      = item.beacon_due && (!item.channel_busy || cfg.full_duplex);
        req      = item.voice_queued || bcn;
        m        = st.mode;
        c        = (st.period_count == COUNT_MAX) ? st.period_count
                                                  : st.period_count + COUNT_W'(1);
        hv       = st.had_voice;
        np       = st.ptt_level;
        in_tail  = 1'b0;
        run_beep = 1'b0;
        run_tail = 1'b0;
        done     = 1'b0;
        consumed = 1'b0;
        src      = SRC_SILENCE;
        bp       = '0;

        unique case (st.mode)
            MODE_OFF:
            begin
                if (req)
                begin
                    m  = MODE_ON;
                    c  = '0;
                    np = PTT_OTHER;
                end
            end
            MODE_ON:
            begin
                if (!req)
                begin
                    c = '0;
                    if (hv && item.aux_beep_enable)
                        m = MODE_BEEP1;
                    else if (hv && item.link_associated)
                        m = MODE_LINK;
                    else
                        m = MODE_TAIL;
                    run_beep = 1'b1;
                end
            end
            MODE_BEEP1, MODE_BEEP2, MODE_LINK:
            begin
                if (req)
                begin
                    in_tail = 1'b1;
                    if (cfg.tail_keys_other)
                        np = PTT_OTHER;
                    m = MODE_ON;
                    c = '0;
                end
                else
                begin
                    run_beep = 1'b1;
                end
            end
            MODE_TAIL:
            begin
                run_tail = 1'b1;
            end
            default:
            begin
                m = MODE_OFF;
            end
        endcase

        // courtesy beep chain
        if (run_beep)
        begin
            in_tail = 1'b1;
            if (cfg.tail_keys_other)
                np = PTT_OTHER;
            if (m == MODE_BEEP1)
            begin
                if (c < {{(COUNT_W-BEEP_W){1'b0}}, cfg.beep1_periods})
                    done = 1'b1;
                else
                begin
                    c = '0;
                    m = item.aux_second_beep ? MODE_BEEP2 : MODE_TAIL;
                end
            end
            if (!done && m == MODE_BEEP2)
            begin
                if (c < {{(COUNT_W-BEEP_W){1'b0}}, cfg.beep2_periods})
                    done = 1'b1;
                else
                begin
                    c = '0;
                    m = MODE_TAIL;
                end
            end
            if (!done && m == MODE_LINK)
            begin
                if (c < {{(COUNT_W-BEEP_W){1'b0}}, cfg.link_beep_periods})
                    done = 1'b1;
                else
                begin
                    c = '0;
                    m = MODE_TAIL;
                end
            end
            run_tail = !done;
        end

        // hang tail
        if (run_tail)
        begin
            in_tail = 1'b1;
            if (cfg.tail_keys_other)
                np = PTT_OTHER;
            if (c >= {{(COUNT_W-TAIL_W){1'b0}}, cfg.tail_periods})
            begin
                m  = MODE_OFF;
                c  = '0;
                hv = 1'b0;
                np = PTT_OFF;
            end
            else if (req)
            begin
                m = MODE_ON;
                c = '0;
            end
        end

        case (m)
            MODE_ON:
            begin
                src = SRC_VOICE;
                if (item.voice_queued)
                begin
                    consumed = 1'b1;
                    hv       = 1'b1;
                end
            end
            MODE_BEEP1:
            begin
                src = SRC_BEEP1;
                bp  = c;
            end
            MODE_BEEP2:
            begin
                src = SRC_BEEP2;
                bp  = c;
            end
            MODE_LINK:
            begin
                src = SRC_LINK;
                bp  = c;
            end
            default:
            begin
                src = SRC_SILENCE;
            end
        endcase

        if (np != PTT_OFF && hv && !in_tail)
            np = PTT_AUDIO;

        nxt.mode         = m;
        nxt.period_count = c;
        nxt.had_voice    = hv;
        nxt.ptt_level    = np;

        res.ptt_drive       = np;
        res.audio_source    = src;
        res.beep_period     = bp;
        res.voice_consumed  = consumed;
        res.subtone_allowed = hv;
        res.transmitting    = (m != MODE_OFF);
    end

endmodule

`default_nettype wire
